// ===== rtl/core/lge_pkg.sv =====
`timescale 1ns / 1ps

package lge_pkg;

  localparam int DEF_GRID_COLS = 64;
  localparam int DEF_GRID_ROWS = 64;

  localparam int FUNC_W = 2;
  localparam int ADDR_W = 6;
  localparam int CNT_W  = 4;

  localparam logic [FUNC_W-1:0] FUNC_TOGGLE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_ACC  = 2'd1,
    RES_GEN  = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     load_acc;
    logic     load_gen;
    logic     fetch;
    logic     gen_write;
    logic     clr_write;
    logic     apply;
    logic     capture;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic req_inside;
    logic acc_fetch_last;
    logic gen_fetch_last;
    logic win_full;
    logic wr_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/life_generation_engine.sv =====
`timescale 1ns / 1ps

// Game of Life (B3/S23) engine on a GRID_COLS x GRID_ROWS grid, dead beyond the
// edges, no wrap. After reset a clearing pass zeroes the row store, with
// in_ready low. Each input beat gives exactly one result beat. For toggle and
// read, three rows (above, at and below the cell) are fetched one per cycle
// through the single read port of the row store, then the cell is updated and
// counted. For advance, the store is swept once through a three-row window, one
// row read and one new row written each cycle, so the read port sets the pace.
// Off-grid accesses and the unused code answer with zeros.
// A finished result waits in an output register while the next beat is taken.
module life_generation_engine #(
  parameter int GRID_COLS = lge_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = lge_pkg::DEF_GRID_ROWS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lge_pkg::FUNC_W-1:0] func,
  input  logic [lge_pkg::ADDR_W-1:0] col,
  input  logic [lge_pkg::ADDR_W-1:0] row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       cell_alive,
  output logic [lge_pkg::CNT_W-1:0]  live_neighbors,
  output logic                       gen_done
);

  lge_pkg::dp_cmd_t  cmd;
  lge_pkg::dp_stat_t stat;

  lge_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lge_datapath #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .func           (func),
    .col            (col),
    .row            (row),
    .cmd            (cmd),
    .stat           (stat),
    .cell_alive     (cell_alive),
    .live_neighbors (live_neighbors),
    .gen_done       (gen_done)
  );

endmodule

// ===== rtl/core/lge_datapath.sv =====
`timescale 1ns / 1ps

module lge_datapath #(
  parameter int GRID_COLS = lge_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = lge_pkg::DEF_GRID_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lge_pkg::FUNC_W-1:0]  func,
  input  logic [lge_pkg::ADDR_W-1:0]  col,
  input  logic [lge_pkg::ADDR_W-1:0]  row,
  input  lge_pkg::dp_cmd_t            cmd,
  output lge_pkg::dp_stat_t           stat,
  output logic                        cell_alive,
  output logic [lge_pkg::CNT_W-1:0]   live_neighbors,
  output logic                        gen_done
);

  localparam int RA_W  = $clog2(GRID_ROWS);
  localparam int PTR_W = $clog2(GRID_ROWS + 2);
  localparam int CI_W  = $clog2(GRID_COLS);

  // row store
  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_COLS-1:0] mem_q;
  logic                 mem_we;
  logic [RA_W-1:0]      mem_wa;
  logic [GRID_COLS-1:0] mem_wd;

  // fetch pointer holds row + 1, so 0 and GRID_ROWS + 1 are the dead rows past each edge
  logic [PTR_W-1:0]     ptr;
  logic [PTR_W-1:0]     acc_end;
  logic                 rd_ok;
  logic [RA_W-1:0]      rd_addr;
  logic                 fetch_q;
  logic                 ok_q;

  logic [GRID_COLS-1:0] win_up;
  logic [GRID_COLS-1:0] win_mid;
  logic [GRID_COLS-1:0] win_dn;
  logic [1:0]           win_cnt;
  logic [RA_W-1:0]      wr_row;

  logic [RA_W-1:0]      acc_ra;
  logic [CI_W-1:0]      acc_ci;
  logic                 acc_toggle;

  logic [GRID_COLS+1:0] up_p;
  logic [GRID_COLS+1:0] mid_p;
  logic [GRID_COLS+1:0] dn_p;
  logic [GRID_COLS-1:0] next_row;
  logic [GRID_COLS-1:0] tog_mask;
  logic [2:0]           acc_up3;
  logic [2:0]           acc_mid3;
  logic [2:0]           acc_dn3;
  logic [lge_pkg::CNT_W-1:0] acc_cnt;

  function automatic logic [lge_pkg::CNT_W-1:0] nb_count(
    input logic [2:0] a,
    input logic [2:0] m,
    input logic [2:0] b
  );
    nb_count = {3'd0, a[0]} + {3'd0, a[1]} + {3'd0, a[2]}
             + {3'd0, m[0]} + {3'd0, m[2]}
             + {3'd0, b[0]} + {3'd0, b[1]} + {3'd0, b[2]};
  endfunction

  assign rd_ok   = (ptr != '0) && (ptr <= PTR_W'(GRID_ROWS));
  assign rd_addr = RA_W'(ptr - PTR_W'(1));

  assign stat.req_inside     = (int'(col) < GRID_COLS) && (int'(row) < GRID_ROWS);
  assign stat.acc_fetch_last = (ptr == acc_end);
  assign stat.gen_fetch_last = (ptr == PTR_W'(GRID_ROWS + 1));
  assign stat.win_full       = (win_cnt == 2'd3);
  assign stat.wr_last        = (wr_row == RA_W'(GRID_ROWS - 1));

  assign up_p  = {1'b0, win_up, 1'b0};
  assign mid_p = {1'b0, win_mid, 1'b0};
  assign dn_p  = {1'b0, win_dn, 1'b0};

  // B3/S23 over the whole window, one column per lane
  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      next_row[c] = (nb_count(up_p[c +: 3], mid_p[c +: 3], dn_p[c +: 3]) == 4'd3)
                 || (mid_p[c+1]
                     && nb_count(up_p[c +: 3], mid_p[c +: 3], dn_p[c +: 3]) == 4'd2);
    end
  end

  assign tog_mask = acc_toggle ? (GRID_COLS'(1) << acc_ci) : '0;
  assign acc_up3  = up_p[acc_ci +: 3];
  assign acc_mid3 = mid_p[acc_ci +: 3];
  assign acc_dn3  = dn_p[acc_ci +: 3];
  assign acc_cnt  = nb_count(acc_up3, acc_mid3, acc_dn3);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_row;
    mem_wd = '0;
    priority if (cmd.clr_write) begin
      mem_we = 1'b1;
    end else if (cmd.gen_write) begin
      mem_we = 1'b1;
      mem_wd = next_row;
    end else if (cmd.apply && acc_toggle) begin
      mem_we = 1'b1;
      mem_wa = acc_ra;
      mem_wd = win_mid ^ tog_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.fetch && rd_ok) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      fetch_q <= 1'b0;
      ok_q    <= 1'b0;
      win_cnt <= 2'd0;
      wr_row  <= '0;
    end else begin
      fetch_q <= cmd.fetch;
      ok_q    <= cmd.fetch && rd_ok;
      if (cmd.load_acc) begin
        ptr     <= PTR_W'(row);
        win_cnt <= 2'd0;
      end else if (cmd.load_gen) begin
        ptr     <= '0;
        win_cnt <= 2'd0;
      end else begin
        if (cmd.fetch) begin
          ptr <= ptr + PTR_W'(1);
        end
        if (fetch_q && win_cnt != 2'd3) begin
          win_cnt <= win_cnt + 2'd1;
        end
      end
      if (cmd.load_gen) begin
        wr_row <= '0;
      end else if (cmd.gen_write || cmd.clr_write) begin
        wr_row <= wr_row + RA_W'(1);
      end
    end
  end

  // access address and window shift
  always_ff @(posedge clk) begin
    if (cmd.load_acc) begin
      acc_ra     <= RA_W'(row);
      acc_ci     <= CI_W'(col);
      acc_end    <= PTR_W'(row) + PTR_W'(2);
      acc_toggle <= (func == lge_pkg::FUNC_TOGGLE);
    end
    if (fetch_q) begin
      win_up  <= win_mid;
      win_mid <= win_dn;
      win_dn  <= ok_q ? mem_q : '0;
    end else if (cmd.apply) begin
      win_mid <= win_mid ^ tog_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      unique case (cmd.res_sel)
        lge_pkg::RES_ACC: begin
          cell_alive     <= acc_mid3[1];
          live_neighbors <= acc_cnt;
          gen_done       <= 1'b0;
        end
        lge_pkg::RES_GEN: begin
          cell_alive     <= 1'b0;
          live_neighbors <= '0;
          gen_done       <= 1'b1;
        end
        default: begin
          cell_alive     <= 1'b0;
          live_neighbors <= '0;
          gen_done       <= 1'b0;
        end
      endcase
    end
  end

  a_gen_write_full: assert property (@(posedge clk) disable iff (rst)
    cmd.gen_write |-> win_cnt == 2'd3)
    else $error("generation row written before window filled");

  a_apply_settled: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> (win_cnt == 2'd3) && !fetch_q)
    else $error("access applied while window still shifting");

  a_toggle_flips: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && acc_toggle |=> win_mid != $past(win_mid))
    else $error("toggle left the center row unchanged");

endmodule

// ===== rtl/core/lge_ctrl.sv =====
`timescale 1ns / 1ps

module lge_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lge_pkg::FUNC_W-1:0] func,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  lge_pkg::dp_stat_t          stat,
  output lge_pkg::dp_cmd_t           cmd
);

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_ACC_FETCH = 7'b0000100,
    S_ACC_WAIT  = 7'b0001000,
    S_GEN_FETCH = 7'b0010000,
    S_GEN_RUN   = 7'b0100000,
    S_RESP      = 7'b1000000
  } state_t;

  state_t            state;
  state_t            state_next;
  lge_pkg::res_sel_t res_sel;
  lge_pkg::res_sel_t res_sel_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    res_sel_next  = res_sel;
    cmd           = '0;
    cmd.res_sel   = res_sel;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.wr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          priority if (func == lge_pkg::FUNC_ADVANCE) begin
            cmd.load_gen = 1'b1;
            res_sel_next = lge_pkg::RES_GEN;
            state_next   = S_GEN_FETCH;
          end else if ((func == lge_pkg::FUNC_TOGGLE || func == lge_pkg::FUNC_READ)
                       && stat.req_inside) begin
            cmd.load_acc = 1'b1;
            res_sel_next = lge_pkg::RES_ACC;
            state_next   = S_ACC_FETCH;
          end else begin
            // off-grid access or unused code: all-zero result
            res_sel_next = lge_pkg::RES_NONE;
            state_next   = S_RESP;
          end
        end
      end
      S_ACC_FETCH: begin
        cmd.fetch = 1'b1;
        if (stat.acc_fetch_last) begin
          state_next = S_ACC_WAIT;
        end
      end
      S_ACC_WAIT: begin
        if (stat.win_full) begin
          cmd.apply  = 1'b1;
          state_next = S_RESP;
        end
      end
      S_GEN_FETCH: begin
        cmd.fetch     = 1'b1;
        cmd.gen_write = stat.win_full;
        if (stat.gen_fetch_last) begin
          state_next = S_GEN_RUN;
        end
      end
      S_GEN_RUN: begin
        cmd.gen_write = stat.win_full;
        if (stat.win_full && stat.wr_last) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      res_sel   <= lge_pkg::RES_NONE;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      res_sel <= res_sel_next;
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_capture_free: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !out_valid || out_ready)
    else $error("result captured over a beat not yet taken");

  a_advance_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == lge_pkg::FUNC_ADVANCE |=> state == S_GEN_FETCH)
    else $error("advance beat did not start the sweep");

  a_valid_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESP))
    else $error("result raised outside response state");

endmodule

// ===== verif/lge_checker.sv =====
`timescale 1ns / 1ps

module lge_checker #(
  parameter int GRID_COLS = lge_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = lge_pkg::DEF_GRID_ROWS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [lge_pkg::FUNC_W-1:0] func,
  input  logic [lge_pkg::ADDR_W-1:0] col,
  input  logic [lge_pkg::ADDR_W-1:0] row,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       cell_alive,
  input  logic [lge_pkg::CNT_W-1:0]  live_neighbors,
  input  logic                       gen_done,
  output int                         fails,
  output int                         pending
);

  import lge_pkg::*;

  typedef struct packed {
    logic             alive;
    logic [CNT_W-1:0] nbrs;
    logic             done;
  } life_answer_t;

  logic [GRID_COLS-1:0] shadow_grid [GRID_ROWS];
  life_answer_t         answers_due [$];

  function automatic logic cell_at(int c, int r);
    if (c < 0 || r < 0 || c >= GRID_COLS || r >= GRID_ROWS) return 1'b0;
    return shadow_grid[r][c];
  endfunction

  function automatic int live_around(int c, int r);
    int n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (dr != 0 || dc != 0) n += cell_at(c + dc, r + dr);
    return n;
  endfunction

  // every cell's next state comes from the old generation only
  function automatic void next_generation();
    logic [GRID_COLS-1:0] nxt [GRID_ROWS];
    int n;
    for (int r = 0; r < GRID_ROWS; r++)
      for (int c = 0; c < GRID_COLS; c++) begin
        n = live_around(c, r);
        nxt[r][c] = (n == 3) || (shadow_grid[r][c] && n == 2);
      end
    shadow_grid = nxt;
  endfunction

  function automatic life_answer_t life_apply(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] c,
                                              logic [ADDR_W-1:0] r);
    life_answer_t ans;
    bit on_grid;
    ans = '0;
    on_grid = (int'(c) < GRID_COLS) && (int'(r) < GRID_ROWS);
    case (f)
      FUNC_ADVANCE: begin
        next_generation();
        ans.done = 1'b1;
      end
      FUNC_TOGGLE, FUNC_READ: begin
        if (on_grid) begin
          if (f == FUNC_TOGGLE) shadow_grid[r][c] = ~shadow_grid[r][c];
          ans.alive = cell_at(c, r);
          ans.nbrs  = CNT_W'(live_around(c, r));
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    life_answer_t want;
    life_answer_t fresh;
    if (rst) begin
      for (int r = 0; r < GRID_ROWS; r++) shadow_grid[r] = '0;
      answers_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        fresh = life_apply(func, col, row);
        answers_due.insert(answers_due.size(), fresh);
      end
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $error("result beat with no expected answer waiting");
          fails++;
        end else begin
          want = answers_due.pop_front();
          check_field("cell_alive", want.alive, cell_alive);
          check_field("live_neighbors", want.nbrs, live_neighbors);
          check_field("gen_done", want.done, gen_done);
        end
      end
    end
    pending = answers_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  import lge_pkg::*;

  localparam int                COLS        = DEF_GRID_COLS;
  localparam int                ROWS        = DEF_GRID_ROWS;
  localparam int                N_ITEMS     = 1650;
  localparam int                RX_HOLD     = 400;
  localparam int                CYCLE_LIMIT = 2_000_000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] func           = '0;
  logic [ADDR_W-1:0] col            = '0;
  logic [ADDR_W-1:0] row            = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic              cell_alive;
  logic [CNT_W-1:0]  live_neighbors;
  logic              gen_done;

  int fails;
  int pending;
  int sent_count  = 0;
  int cycle_count = 0;
  bit tx_quiet    = 1'b0;
  bit rx_quiet    = 1'b0;
  bit rx_hold_req = 1'b0;

  life_generation_engine u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .col(col), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_alive(cell_alive), .live_neighbors(live_neighbors), .gen_done(gen_done)
  );

  lge_checker #(.GRID_COLS(COLS), .GRID_ROWS(ROWS)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .col(col), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_alive(cell_alive), .live_neighbors(live_neighbors), .gen_done(gen_done),
    .fails(fails), .pending(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** life_generation_engine: FAILED **");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic int pick_coord();
    int edges [4] = '{0, 1, COLS - 2, COLS - 1};
    if ($urandom_range(0, 9) < 3) return edges[$urandom_range(0, 3)];
    return $urandom_range(0, COLS - 1);
  endfunction

  function automatic int near(int ctr, int lim);
    int v;
    v = ctr + $urandom_range(0, 4) - 2;
    if (v < 0) return 0;
    if (v > lim - 1) return lim - 1;
    return v;
  endfunction

  // called at a rising edge; returns at the edge where the beat was taken, or after a random idle gap
  task automatic send_beat(logic [FUNC_W-1:0] f, int c, int r);
    int gap;
    in_valid <= 1'b1;
    func     <= f;
    col      <= ADDR_W'(c);
    row      <= ADDR_W'(r);
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent_count++;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic pattern_session();
    int cx, cy, k;
    cx = pick_coord();
    cy = pick_coord();
    k  = $urandom_range(3, 10);
    repeat (k) begin
      send_beat(FUNC_TOGGLE, near(cx, COLS), near(cy, ROWS));
      if ($urandom_range(0, 2) == 0) send_beat(FUNC_READ, near(cx, COLS), near(cy, ROWS));
    end
    repeat ($urandom_range(1, 4)) begin
      send_beat(FUNC_ADVANCE, $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1));
      repeat ($urandom_range(1, 3)) send_beat(FUNC_READ, near(cx, COLS), near(cy, ROWS));
    end
  endtask

  // receiver: random stalls, quiet stretches, and one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left  = RX_HOLD;
      end
      if ($urandom_range(0, 299) == 0) rx_quiet = !rx_quiet;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    int pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner block: three cells, fourth is born on advance
    send_beat(FUNC_READ, 0, 0);
    send_beat(FUNC_TOGGLE, 0, 0);
    send_beat(FUNC_TOGGLE, 1, 0);
    send_beat(FUNC_TOGGLE, 0, 1);
    send_beat(FUNC_READ, 1, 1);
    send_beat(FUNC_UNUSED, COLS - 1, ROWS - 1);
    send_beat(FUNC_TOGGLE, COLS - 1, ROWS - 1);
    send_beat(FUNC_READ, COLS - 2, ROWS - 2);
    send_beat(FUNC_ADVANCE, COLS - 1, ROWS - 1);
    send_beat(FUNC_READ, 1, 1);
    // blinker on the right edge, one of its three cells falls off the grid
    send_beat(FUNC_TOGGLE, COLS - 1, 30);
    send_beat(FUNC_TOGGLE, COLS - 1, 31);
    send_beat(FUNC_TOGGLE, COLS - 1, 32);
    send_beat(FUNC_ADVANCE, 0, 0);
    send_beat(FUNC_READ, COLS - 1, 31);
    send_beat(FUNC_READ, COLS - 2, 31);
    // full ring of eight, then overcrowding
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (dr != 0 || dc != 0) send_beat(FUNC_TOGGLE, 20 + dc, 40 + dr);
    send_beat(FUNC_READ, 20, 40);
    send_beat(FUNC_ADVANCE, 0, 0);
    drain_pause();

    // sender keeps pushing while the receiver holds off
    rx_hold_req = 1'b1;
    tx_quiet    = 1'b1;
    repeat (20) send_beat(FUNC_READ, $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1));

    while (sent_count < N_ITEMS) begin
      pick     = $urandom_range(0, 99);
      tx_quiet = ($urandom_range(0, 4) == 0);
      if (pick < 4) drain_pause();
      else if (pick < 70) pattern_session();
      else if (pick < 90) begin
        repeat ($urandom_range(1, 6))
          send_beat(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, COLS - 1),
                    $urandom_range(0, ROWS - 1));
      end else send_beat(FUNC_ADVANCE, $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1));
    end

    drain_pause();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("** life_generation_engine: PASSED **");
    end else begin
      $display("** life_generation_engine: FAILED **");
    end
    $finish;
  end

endmodule
